@@ src/assert_macros.svh @@
// ----------------------------------------------------------------------------
// assertion macros
// concurrent checks that compile away when SYNTHESIS is defined
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define ASSERT_PROP(lbl, clk, rstn, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!(rstn)) (prop)) else $error(msg);
`define ASSERT_NEVER(lbl, clk, rstn, cond, msg) \
  `ASSERT_PROP(lbl, clk, rstn, !(cond), msg)
`else
`define ASSERT_PROP(lbl, clk, rstn, prop, msg)
`define ASSERT_NEVER(lbl, clk, rstn, cond, msg)
`endif
`endif

@@ src/drdb_pkg.sv @@
// ----------------------------------------------------------------------------
// drdb_pkg
// shared constants, types and helpers of the dead-block drrip policy
// ----------------------------------------------------------------------------
`default_nettype none

package drdb_pkg;

  localparam int NUM_SETS      = 2048;
  localparam int NUM_WAYS      = 16;
  localparam int LEADER_SETS   = 64;
  localparam int SELECTOR_BITS = 10;

  localparam int SET_BITS    = $clog2(NUM_SETS);
  localparam int WAY_BITS    = $clog2(NUM_WAYS);
  localparam int ROW_W       = 2 * NUM_WAYS;
  localparam int SET_FIELD_W = 11;
  localparam int WAY_FIELD_W = 4;
  localparam int MASK_W      = 16;
  localparam int MASK_WAYS   = (NUM_WAYS < MASK_W) ? NUM_WAYS : MASK_W;
  localparam int VICTIM_W    = 4;
  localparam int SEL_OUT_W   = 10;

  typedef logic [SET_BITS-1:0]      set_t;
  typedef logic [WAY_BITS-1:0]      way_t;
  typedef logic [ROW_W-1:0]         row_t;
  typedef logic [SELECTOR_BITS-1:0] sel_t;

  localparam logic [1:0] FUNC_VICTIM = 2'd0;
  localparam logic [1:0] FUNC_UPDATE = 2'd1;
  localparam logic [1:0] FUNC_DECAY  = 2'd2;

  localparam logic [1:0] RRPV_DISTANT = 2'd3;
  localparam logic [1:0] RRPV_LONG    = 2'd2;
  localparam logic [1:0] RRPV_NEAR    = 2'd0;
  localparam logic [1:0] DEAD_MAX     = 2'd3;
  localparam logic [1:0] DEAD_NONE    = 2'd0;

  localparam row_t RR_RESET = '1;
  localparam row_t DC_RESET = '0;
  localparam set_t SET_LAST = set_t'(NUM_SETS - 1);

  localparam sel_t SEL_MAX = '1;
  localparam sel_t SEL_MID = sel_t'(1) << (SELECTOR_BITS - 1);
  localparam sel_t SEL_MIN = '0;

  typedef struct packed {
    logic [1:0]             func;
    set_t                   set;
    logic [WAY_FIELD_W-1:0] way;
    logic                   hit;
    logic [MASK_W-1:0]      mask;
  } op_t;

  typedef struct packed {
    logic wr_rr;
    logic wr_dc;
    row_t rr_row;
    row_t dc_row;
    way_t victim;
    sel_t sel;
  } pol_res_t;

  typedef enum logic [2:0] {
    ST_INIT,
    ST_IDLE,
    ST_EXEC,
    ST_DECAY,
    ST_DRAIN,
    ST_DONE
  } state_t;

  function automatic set_t to_set(input logic [SET_FIELD_W-1:0] idx);
    logic [SET_BITS+SET_FIELD_W-1:0] tmp;
    tmp = {{SET_BITS{1'b0}}, idx};
    return tmp[SET_BITS-1:0];
  endfunction

  function automatic row_t decay_row(input row_t row);
    row_t r;
    r = row;
    for (int w = 0; w < NUM_WAYS; w++) begin
      if (row[2*w +: 2] != DEAD_NONE) begin
        r[2*w +: 2] = row[2*w +: 2] - 2'd1;
      end
    end
    return r;
  endfunction

  function automatic logic [SEL_OUT_W-1:0] sel_out(input sel_t sel);
    logic [SELECTOR_BITS+SEL_OUT_W-1:0] tmp;
    tmp = {{SEL_OUT_W{1'b0}}, sel};
    return tmp[SEL_OUT_W-1:0];
  endfunction

  function automatic logic [VICTIM_W-1:0] victim_out(input way_t way);
    logic [WAY_BITS+VICTIM_W-1:0] tmp;
    tmp = {{VICTIM_W{1'b0}}, way};
    return tmp[VICTIM_W-1:0];
  endfunction

endpackage

`default_nettype wire

@@ src/drdb_ram.sv @@
// ----------------------------------------------------------------------------
// drdb_ram
// simple dual-port synchronous ram, one write and one registered read port
// ----------------------------------------------------------------------------
`default_nettype none

module drdb_ram #(
  parameter int DEPTH = 2048,
  parameter int WIDTH = 32
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem_r [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem_r[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem_r[rd_addr];
    end
  end

endmodule

`default_nettype wire

@@ src/drdb_policy.sv @@
// ----------------------------------------------------------------------------
// drdb_policy
// victim choice, set aging and hit or fill update on one read set row
// ----------------------------------------------------------------------------
`default_nettype none

module drdb_policy (
  input  drdb_pkg::op_t      op,
  input  drdb_pkg::row_t     rr_row,
  input  drdb_pkg::row_t     dc_row,
  input  drdb_pkg::sel_t     sel,
  output drdb_pkg::pol_res_t res
);
  import drdb_pkg::*;

  logic [NUM_WAYS-1:0] vmask;
  logic [NUM_WAYS-1:0] free_w;
  logic [NUM_WAYS-1:0] hi_w;
  logic [NUM_WAYS-1:0] lo_w;
  logic [NUM_WAYS-1:0] top3_w;
  logic [1:0]          top;
  logic [1:0]          aging;
  row_t                aged;
  logic                free_any;
  way_t                free_idx;
  way_t                top_idx;
  logic                srrip_lead;
  logic                brrip_lead;
  logic                brrip;
  logic                way_ok;
  logic [1:0]          old_dc;
  logic [1:0]          ins;
  logic [1:0]          new_dc;

  // victim search and aging
  always_comb begin
    vmask = '1;
    for (int w = 0; w < MASK_WAYS; w++) begin
      vmask[w] = op.mask[w];
    end
    for (int w = 0; w < NUM_WAYS; w++) begin
      free_w[w] = !vmask[w] || (dc_row[2*w +: 2] == DEAD_MAX);
      hi_w[w]   = rr_row[2*w+1];
      lo_w[w]   = rr_row[2*w];
    end
    free_any = |free_w;
    top[1]   = |hi_w;
    top[0]   = top[1] ? |(hi_w & lo_w) : |lo_w;
    aging    = RRPV_DISTANT - top;
    for (int w = 0; w < NUM_WAYS; w++) begin
      aged[2*w +: 2] = rr_row[2*w +: 2] + aging;
      top3_w[w]      = (aged[2*w +: 2] == RRPV_DISTANT);
    end
    free_idx = '0;
    top_idx  = '0;
    for (int w = NUM_WAYS - 1; w >= 0; w--) begin
      if (free_w[w]) begin
        free_idx = way_t'(w);
      end
      if (top3_w[w]) begin
        top_idx = way_t'(w);
      end
    end
  end

  // insertion decision
  always_comb begin
    way_ok = 32'(op.way) < NUM_WAYS;
    old_dc = DEAD_NONE;
    for (int w = 0; w < NUM_WAYS; w++) begin
      if (32'(op.way) == w) begin
        old_dc = dc_row[2*w +: 2];
      end
    end
    srrip_lead = 32'(op.set) < (LEADER_SETS / 2);
    brrip_lead = !srrip_lead && (32'(op.set) < LEADER_SETS);
    if (srrip_lead) begin
      brrip = 1'b0;
    end else if (brrip_lead) begin
      brrip = 1'b1;
    end else begin
      brrip = sel < SEL_MID;
    end
    ins = (brrip || old_dc == DEAD_MAX) ? RRPV_DISTANT : RRPV_LONG;
    if (ins != RRPV_DISTANT) begin
      new_dc = DEAD_NONE;
    end else if (old_dc == DEAD_MAX) begin
      new_dc = old_dc;
    end else begin
      new_dc = old_dc + 2'd1;
    end
  end

  always_comb begin
    res.wr_rr  = 1'b0;
    res.wr_dc  = 1'b0;
    res.rr_row = rr_row;
    res.dc_row = dc_row;
    res.victim = '0;
    res.sel    = sel;
    case (op.func)
      FUNC_VICTIM: begin
        if (free_any) begin
          res.victim = free_idx;
        end else begin
          res.victim = top_idx;
          res.rr_row = aged;
          res.wr_rr  = 1'b1;
        end
      end
      FUNC_UPDATE: begin
        if (way_ok) begin
          res.wr_rr = 1'b1;
          res.wr_dc = 1'b1;
          for (int w = 0; w < NUM_WAYS; w++) begin
            if (32'(op.way) == w) begin
              res.rr_row[2*w +: 2] = op.hit ? RRPV_NEAR : ins;
              res.dc_row[2*w +: 2] = op.hit ? DEAD_NONE : new_dc;
            end
          end
          if (op.hit) begin
            if (srrip_lead && sel != SEL_MAX) begin
              res.sel = sel + sel_t'(1);
            end
            if (brrip_lead && sel != SEL_MIN) begin
              res.sel = sel - sel_t'(1);
            end
          end
        end
      end
      default: begin
      end
    endcase
  end

endmodule

`default_nettype wire

@@ src/drrip_dead_block_replacement.sv @@
// ----------------------------------------------------------------------------
// drrip_dead_block_replacement
// dead-block aware drrip replacement policy for a last-level cache
// ----------------------------------------------------------------------------
// in channel: tuser = {hit, func}, tdata = {valid_mask, way_index, set_index}.
// out channel: one item per input item, tdata = {selector_value, victim_way}.
// per-set re-reference and dead-counter rows sit in two synchronous rams; the
// set row is read when the item is taken and written back once output is free.
// victim select and update: the result is registered after the ram read; no new
// item is taken until the read-modify-write of one set row has been done.
// heartbeat decay: sweeps every set of the dead-counter ram, one row a cycle;
// the result is loaded after the sweep, and no new item is taken until then.
// after reset a clearing pass writes the reset rows into every set; in_tready
// stays low until it ends.
// the result sits in an output register: the block takes the next item while
// it waits, and stalls before write-back while the previous result is held.
// ----------------------------------------------------------------------------
`default_nettype none
`include "assert_macros.svh"

module drrip_dead_block_replacement (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [31:0] in_tdata,   // set_index[10:0], way_index[14:11], valid_mask[30:15]
  input  logic [2:0]  in_tuser,   // func[1:0], hit[2]
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [15:0] out_tdata   // victim_way[3:0], selector_value[13:4]
);
  import drdb_pkg::*;

  state_t                 state_r, state_nxt;
  set_t                   cnt_r, cnt_nxt;
  sel_t                   sel_r, sel_nxt;
  op_t                    op_r;
  logic                   out_valid_r, out_valid_nxt;
  logic [VICTIM_W-1:0]    out_victim_r, out_victim_nxt;
  logic [SEL_OUT_W-1:0]   out_sel_r, out_sel_nxt;
  logic                   out_load;
  logic                   out_free;
  logic                   accept;
  set_t                   in_set;
  logic                   mem_re;
  set_t                   mem_raddr;
  set_t                   wr_addr;
  logic                   rr_we;
  logic                   dc_we;
  row_t                   rr_wdata;
  row_t                   dc_wdata;
  row_t                   rr_rdata;
  row_t                   dc_rdata;
  pol_res_t               pol;

  assign in_set   = to_set(in_tdata[SET_FIELD_W-1:0]);
  assign accept   = in_tvalid && in_tready;
  assign out_free = !out_valid_r || out_tready;

  drdb_ram #(.DEPTH(NUM_SETS), .WIDTH(ROW_W)) u_rr_ram (
    .clk     (clk),
    .wr_en   (rr_we),
    .wr_addr (wr_addr),
    .wr_data (rr_wdata),
    .rd_en   (mem_re),
    .rd_addr (mem_raddr),
    .rd_data (rr_rdata)
  );

  drdb_ram #(.DEPTH(NUM_SETS), .WIDTH(ROW_W)) u_dc_ram (
    .clk     (clk),
    .wr_en   (dc_we),
    .wr_addr (wr_addr),
    .wr_data (dc_wdata),
    .rd_en   (mem_re),
    .rd_addr (mem_raddr),
    .rd_data (dc_rdata)
  );

  drdb_policy u_policy (
    .op     (op_r),
    .rr_row (rr_rdata),
    .dc_row (dc_rdata),
    .sel    (sel_r),
    .res    (pol)
  );

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_INIT: begin
        if (cnt_r == SET_LAST) begin
          state_nxt = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (in_tvalid) begin
          state_nxt = (in_tuser[1:0] == FUNC_DECAY) ? ST_DECAY : ST_EXEC;
        end
      end
      ST_EXEC: begin
        if (out_free) begin
          state_nxt = ST_IDLE;
        end
      end
      ST_DECAY: begin
        if (cnt_r == SET_LAST) begin
          state_nxt = ST_DRAIN;
        end
      end
      ST_DRAIN: begin
        state_nxt = ST_DONE;
      end
      ST_DONE: begin
        if (out_free) begin
          state_nxt = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_INIT;
      end
    endcase
  end

  always_comb begin
    in_tready      = 1'b0;
    mem_re         = 1'b0;
    mem_raddr      = in_set;
    wr_addr        = op_r.set;
    rr_we          = 1'b0;
    dc_we          = 1'b0;
    rr_wdata       = pol.rr_row;
    dc_wdata       = pol.dc_row;
    cnt_nxt        = cnt_r;
    sel_nxt        = sel_r;
    out_load       = 1'b0;
    out_victim_nxt = out_victim_r;
    out_sel_nxt    = out_sel_r;
    case (state_r)
      ST_INIT: begin
        rr_we    = 1'b1;
        dc_we    = 1'b1;
        wr_addr  = cnt_r;
        rr_wdata = RR_RESET;
        dc_wdata = DC_RESET;
        cnt_nxt  = (cnt_r == SET_LAST) ? '0 : cnt_r + set_t'(1);
      end
      ST_IDLE: begin
        in_tready = 1'b1;
        mem_re    = in_tvalid;
        cnt_nxt   = '0;
      end
      ST_EXEC: begin
        if (out_free) begin
          rr_we          = pol.wr_rr;
          dc_we          = pol.wr_dc;
          sel_nxt        = pol.sel;
          out_load       = 1'b1;
          out_victim_nxt = victim_out(pol.victim);
          out_sel_nxt    = sel_out(pol.sel);
        end
      end
      ST_DECAY: begin
        mem_re    = 1'b1;
        mem_raddr = cnt_r;
        dc_we     = (cnt_r != '0);
        wr_addr   = cnt_r - set_t'(1);
        dc_wdata  = decay_row(dc_rdata);
        cnt_nxt   = (cnt_r == SET_LAST) ? cnt_r : cnt_r + set_t'(1);
      end
      ST_DRAIN: begin
        dc_we    = 1'b1;
        wr_addr  = cnt_r;
        dc_wdata = decay_row(dc_rdata);
      end
      ST_DONE: begin
        if (out_free) begin
          out_load       = 1'b1;
          out_victim_nxt = '0;
          out_sel_nxt    = sel_out(sel_r);
        end
      end
      default: begin
      end
    endcase
  end

  assign out_valid_nxt = out_load || (out_valid_r && !out_tready);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_INIT;
      cnt_r       <= '0;
      sel_r       <= SEL_MID;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      cnt_r       <= cnt_nxt;
      sel_r       <= sel_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      op_r.func <= in_tuser[1:0];
      op_r.set  <= in_set;
      op_r.way  <= in_tdata[SET_FIELD_W +: WAY_FIELD_W];
      op_r.hit  <= in_tuser[2];
      op_r.mask <= in_tdata[SET_FIELD_W+WAY_FIELD_W +: MASK_W];
    end
    out_victim_r <= out_victim_nxt;
    out_sel_r    <= out_sel_nxt;
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {2'b00, out_sel_r, out_victim_r};

  `ASSERT_PROP(a_accept_starts_work, clk, rst_n, accept |=> state_r == ST_EXEC || state_r == ST_DECAY, "accepted item did not start work")
  `ASSERT_NEVER(a_no_write_in_idle, clk, rst_n, (rr_we || dc_we) && state_r == ST_IDLE, "ram write while idle")
  `ASSERT_PROP(a_sel_from_exec, clk, rst_n, $past(rst_n) && sel_r != $past(sel_r) |-> $past(state_r) == ST_EXEC, "selector changed outside update")
  `ASSERT_PROP(a_out_from_result, clk, rst_n, $past(rst_n) && $rose(out_valid_r) |-> $past(state_r == ST_EXEC || state_r == ST_DONE), "result item from wrong state")

endmodule

`default_nettype wire

@@ bench/drrip_dead_block_replacement_tb.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// drrip_dead_block_replacement_tb
// streams victim-select, update, heartbeat-decay and no-op items through the
// policy, tracks its own copy of the per-set rrpv and dead-counter state and
// the duel selector, and checks each result item in order under random sender
// bursts, receiver stalls and one long receiver hold-off
// ----------------------------------------------------------------------------
module drrip_dead_block_replacement_tb;
  import drdb_pkg::*;

  localparam logic [1:0] FUNC_NOP = 2'd3;

  localparam int RUN_LIMIT        = 1000000;
  localparam int DRAIN_CYCLES     = NUM_SETS + 16;
  localparam int STEER_UP_ITEMS   = 630;
  localparam int STEER_DOWN_ITEMS = 600;
  localparam int STEER_PCT        = 93;
  localparam int HOLD_AFTER       = 400;
  localparam int HOLD_CYCLES      = 600;

  typedef struct packed {
    logic [3:0] victim;
    logic [9:0] sel;
  } victim_sel_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_tvalid = 1'b0;
  logic        in_tready;
  logic [31:0] in_tdata = '0;   // set_index[10:0], way_index[14:11], valid_mask[30:15]
  logic [2:0]  in_tuser = '0;   // func[1:0], hit[2]
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [15:0] out_tdata;       // victim_way[3:0], selector_value[13:4]

  logic [1:0] rrpv     [NUM_SETS][NUM_WAYS];
  logic [1:0] dead_cnt [NUM_SETS][NUM_WAYS];
  sel_t       duel_sel;

  op_t         pending_ops[$];
  victim_sel_t expected_victim_sel[$];
  int          hot_sets[10];

  int         item_total = 0;
  int         burst_left = 0;
  int         gap_left = 0;
  int         hold_left = 0;
  logic       hold_done = 1'b0;
  int         stall_timer = 0;
  logic [7:0] stall_pat = 8'hff;
  int         results_seen = 0;
  int         mismatch_count = 0;
  int         cycle_count = 0;

  drrip_dead_block_replacement i_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  task automatic apply_policy_op(input logic [1:0] func, input logic [10:0] set_field,
                                 input logic [3:0] way_field, input logic hit,
                                 input logic [15:0] mask, output victim_sel_t res);
    int         s;
    int         w;
    logic [1:0] top;
    logic [1:0] ins;
    logic       srrip_lead;
    logic       brrip_lead;
    logic       brrip_pick;
    logic       found;
    res = '0;
    s = int'(set_field) % NUM_SETS;
    w = int'(way_field);
    case (func)
      FUNC_VICTIM: begin
        found = 1'b0;
        for (int i = 0; i < NUM_WAYS; i++) begin
          if (!found && ((i < MASK_W && !mask[i]) || dead_cnt[s][i] == DEAD_MAX)) begin
            res.victim = 4'(i);
            found = 1'b1;
          end
        end
        if (!found) begin
          // age the whole set until its oldest block reaches distant
          top = RRPV_NEAR;
          for (int i = 0; i < NUM_WAYS; i++)
            if (rrpv[s][i] > top) top = rrpv[s][i];
          for (int i = 0; i < NUM_WAYS; i++)
            rrpv[s][i] = rrpv[s][i] + (RRPV_DISTANT - top);
          for (int i = 0; i < NUM_WAYS; i++) begin
            if (!found && rrpv[s][i] == RRPV_DISTANT) begin
              res.victim = 4'(i);
              found = 1'b1;
            end
          end
        end
      end
      FUNC_UPDATE: if (w < NUM_WAYS) begin
        srrip_lead = (s < LEADER_SETS / 2);
        brrip_lead = !srrip_lead && (s < LEADER_SETS);
        brrip_pick = srrip_lead ? 1'b0 : (brrip_lead ? 1'b1 : (duel_sel < SEL_MID));
        ins = (brrip_pick || dead_cnt[s][w] == DEAD_MAX) ? RRPV_DISTANT : RRPV_LONG;
        if (hit) begin
          rrpv[s][w] = RRPV_NEAR;
          dead_cnt[s][w] = DEAD_NONE;
          if (srrip_lead && duel_sel != SEL_MAX) duel_sel = duel_sel + 1'b1;
          if (brrip_lead && duel_sel != SEL_MIN) duel_sel = duel_sel - 1'b1;
        end else begin
          rrpv[s][w] = ins;
          if (dead_cnt[s][w] != DEAD_MAX) dead_cnt[s][w] = dead_cnt[s][w] + 2'd1;
          if (ins != RRPV_DISTANT) dead_cnt[s][w] = DEAD_NONE;
        end
      end
      FUNC_DECAY: begin
        for (int si = 0; si < NUM_SETS; si++)
          for (int wi = 0; wi < NUM_WAYS; wi++)
            if (dead_cnt[si][wi] != DEAD_NONE) dead_cnt[si][wi] = dead_cnt[si][wi] - 2'd1;
      end
      default: ;
    endcase
    res.sel = duel_sel[9:0];
  endtask

  task automatic queue_op(input logic [1:0] f, input int s, input int w, input logic h,
                          input logic [15:0] m);
    op_t op;
    op.func = f;
    op.set = set_t'(s);
    op.way = 4'(w);
    op.hit = h;
    op.mask = m;
    pending_ops.push_back(op);
  endtask

  task automatic queue_traffic();
    int         kind;
    int         s;
    int         w;
    logic [15:0] m;
    kind = $urandom_range(0, 99);
    s = ($urandom_range(0, 9) == 0) ? $urandom_range(0, NUM_SETS - 1)
                                    : hot_sets[$urandom_range(0, 9)];
    if (kind < 8) begin
      // warm a set: touch every way, then take a victim from it
      for (int i = 0; i < NUM_WAYS; i++)
        queue_op(FUNC_UPDATE, s, i, $urandom_range(0, 3) == 0, 16'($urandom));
      queue_op(FUNC_VICTIM, s, $urandom_range(0, 15), 1'($urandom), 16'hffff);
    end else if (kind < 38) begin
      case ($urandom_range(0, 4))
        0: m = 16'($urandom);
        1: m = ~(16'd1 << $urandom_range(0, 15));
        default: m = 16'hffff;
      endcase
      queue_op(FUNC_VICTIM, s, $urandom_range(0, 15), 1'($urandom), m);
    end else if (kind < 72) begin
      w = ($urandom_range(0, 3) != 0) ? $urandom_range(0, 3) : $urandom_range(0, 15);
      queue_op(FUNC_UPDATE, s, w, 1'b0, 16'($urandom));
    end else if (kind < 87) begin
      queue_op(FUNC_UPDATE, s, $urandom_range(0, 15), 1'b1, 16'($urandom));
    end else if (kind < 95) begin
      queue_op(FUNC_DECAY, $urandom_range(0, NUM_SETS - 1), $urandom_range(0, 15),
               1'($urandom), 16'($urandom));
    end else begin
      queue_op(FUNC_NOP, $urandom_range(0, NUM_SETS - 1), $urandom_range(0, 15),
               1'($urandom), 16'($urandom));
    end
  endtask

  initial begin
    int base;
    for (int si = 0; si < NUM_SETS; si++) begin
      for (int wi = 0; wi < NUM_WAYS; wi++) begin
        rrpv[si][wi] = RRPV_DISTANT;
        dead_cnt[si][wi] = DEAD_NONE;
      end
    end
    duel_sel = SEL_MID;
    hot_sets[0] = 0;
    hot_sets[1] = 1;
    hot_sets[2] = LEADER_SETS / 2 - 1;
    hot_sets[3] = LEADER_SETS / 2;
    hot_sets[4] = LEADER_SETS / 2 + 1;
    hot_sets[5] = LEADER_SETS - 1;
    hot_sets[6] = LEADER_SETS;
    hot_sets[7] = 100;
    hot_sets[8] = 1000;
    hot_sets[9] = NUM_SETS - 1;

    queue_op(FUNC_VICTIM, 5, 0, 1'b0, 16'hffff);
    queue_op(FUNC_VICTIM, 6, 15, 1'b1, 16'hfffe);
    queue_op(FUNC_VICTIM, 6, 0, 1'b0, 16'h7fff);
    queue_op(FUNC_VICTIM, 7, 9, 1'b1, 16'h0000);
    // brrip leader fills push the dead counter to saturation
    repeat (3) queue_op(FUNC_UPDATE, 40, 2, 1'b0, 16'h0000);
    queue_op(FUNC_UPDATE, 40, 2, 1'b0, 16'hffff);
    queue_op(FUNC_VICTIM, 40, 0, 1'b0, 16'hffff);
    queue_op(FUNC_DECAY, NUM_SETS - 1, 15, 1'b1, 16'hffff);
    queue_op(FUNC_VICTIM, 40, 0, 1'b0, 16'hffff);
    queue_op(FUNC_UPDATE, 10, 7, 1'b0, 16'h5555);
    queue_op(FUNC_UPDATE, 10, 7, 1'b1, 16'haaaa);
    queue_op(FUNC_UPDATE, 40, 2, 1'b1, 16'h0000);
    queue_op(FUNC_UPDATE, 0, 0, 1'b1, 16'hffff);
    queue_op(FUNC_VICTIM, 0, 15, 1'b1, 16'hffff);
    queue_op(FUNC_UPDATE, NUM_SETS - 1, 15, 1'b0, 16'h0000);
    queue_op(FUNC_UPDATE, 100, 3, 1'b1, 16'hffff);
    queue_op(FUNC_NOP, NUM_SETS - 1, 15, 1'b1, 16'hffff);
    queue_op(FUNC_NOP, 0, 0, 1'b0, 16'h0000);
    queue_op(FUNC_VICTIM, NUM_SETS - 1, 0, 1'b0, 16'hffff);

    // selector driven up to saturation, then back down below its midpoint
    base = pending_ops.size();
    while (pending_ops.size() < base + STEER_UP_ITEMS) begin
      if ($urandom_range(0, 99) < STEER_PCT)
        queue_op(FUNC_UPDATE, $urandom_range(0, LEADER_SETS / 2 - 1), $urandom_range(0, 15),
                 1'b1, 16'($urandom));
      else
        queue_traffic();
    end
    while (pending_ops.size() < base + STEER_UP_ITEMS + STEER_DOWN_ITEMS) begin
      if ($urandom_range(0, 99) < STEER_PCT)
        queue_op(FUNC_UPDATE, $urandom_range(LEADER_SETS / 2, LEADER_SETS - 1),
                 $urandom_range(0, 15), 1'b1, 16'($urandom));
      else
        queue_traffic();
    end
    item_total = pending_ops.size();

    repeat (6) @(posedge clk);
    rst_n <= 1'b1;

    while (results_seen < item_total || expected_victim_sel.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatch_count == 0)
      $display("Verification passed");
    else
      $display("Verification failed");
    $finish;
  end

  always @(posedge clk) begin : driver
    victim_sel_t res;
    op_t         nxt;
    if (!rst_n) begin
      in_tvalid <= 1'b0;
      burst_left <= 0;
      gap_left <= 0;
    end else begin
      if (in_tvalid && in_tready) begin
        apply_policy_op(in_tuser[1:0], in_tdata[10:0], in_tdata[14:11], in_tuser[2],
                        in_tdata[30:15], res);
        expected_victim_sel.push_back(res);
      end
      if (!in_tvalid || in_tready) begin
        if (gap_left > 0) begin
          gap_left <= gap_left - 1;
          in_tvalid <= 1'b0;
        end else if (pending_ops.size() > 0) begin
          nxt = pending_ops.pop_front();
          in_tdata <= {1'b0, nxt.mask, nxt.way, nxt.set};
          in_tuser <= {nxt.hit, nxt.func};
          in_tvalid <= 1'b1;
          if (burst_left <= 1) begin
            burst_left <= $urandom_range(1, 24);
            gap_left <= ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
          end else begin
            burst_left <= burst_left - 1;
          end
        end else begin
          in_tvalid <= 1'b0;
        end
      end
    end
  end

  always @(posedge clk) begin : monitor
    victim_sel_t want;
    if (!rst_n) begin
      out_tready <= 1'b0;
      stall_pat <= 8'hff;
      stall_timer <= 0;
      results_seen <= 0;
    end else begin
      if (out_tvalid && out_tready) begin
        results_seen <= results_seen + 1;
        if (expected_victim_sel.size() == 0) begin
          $error("unexpected result item: victim_way %0d, selector_value %0d",
                 out_tdata[3:0], out_tdata[13:4]);
          mismatch_count = mismatch_count + 1;
        end else begin
          want = expected_victim_sel.pop_front();
          if (out_tdata[3:0] !== want.victim) begin
            $error("victim_way mismatch: expected %0d, actual %0d", want.victim,
                   out_tdata[3:0]);
            mismatch_count = mismatch_count + 1;
          end
          if (out_tdata[13:4] !== want.sel) begin
            $error("selector_value mismatch: expected %0d, actual %0d", want.sel,
                   out_tdata[13:4]);
            mismatch_count = mismatch_count + 1;
          end
        end
      end
      if (stall_timer == 0) begin
        stall_timer <= 63;
        stall_pat <= ($urandom_range(0, 3) == 0) ? 8'hff : 8'($urandom);
      end else begin
        stall_timer <= stall_timer - 1;
        stall_pat <= {stall_pat[6:0], stall_pat[7]};
      end
      out_tready <= (hold_left == 0) && stall_pat[0];
    end
  end

  // one long hold-off on the result side so the block backs up into its input
  always @(posedge clk) begin
    if (!rst_n) begin
      hold_left <= 0;
      hold_done <= 1'b0;
    end else if (!hold_done && results_seen >= HOLD_AFTER) begin
      hold_left <= HOLD_CYCLES;
      hold_done <= 1'b1;
    end else if (hold_left > 0) begin
      hold_left <= hold_left - 1;
    end
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == RUN_LIMIT) begin
      $display("Verification failed");
      $finish;
    end
  end

endmodule
